>>> hdl/wsof_pkg.sv
// shared types and constants for the window sigma outlier filter
package wsof_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS;
    localparam int WINDOW_DEF  = 5;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          keep;
        logic                          last_out;
    } out_word_t;

    // one position of the sample window
    typedef struct packed {
        logic                          valid;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [SQ_BITS-1:0]            sq;
    } cell_t;

    // what the window hands to the decision pipeline after a shift
    typedef struct packed {
        logic valid;
        logic test;
        logic last;
    } emit_t;

endpackage

>>> hdl/window_sigma_outlier_filter_top.sv
// window sigma outlier filter: sample window chain, running sums, decision pipeline
// throughput: one sample per cycle while the output buffer has room, set by the
// one-shift-per-cycle cell chain; a word marked last blocks input while the chain
// drains the held samples, one per cycle unless stalled, through the same pipeline
// reset: asynchronous, clears the window, the running sums and all control state
module window_sigma_outlier_filter_top #(
    parameter int WINDOW = wsof_pkg::WINDOW_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                feed_valid,
    output logic                feed_stall,
    input  wsof_pkg::in_word_t  feed_data,
    output logic                result_valid,
    input  logic                result_stall,
    output wsof_pkg::out_word_t result_data
);
    import wsof_pkg::*;

    localparam int CENTRE = (WINDOW - 1) / 2;
    localparam int DELAY  = WINDOW - 1 - CENTRE;
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW) + 1;
    localparam int QSUM_W = SQ_BITS + $clog2(WINDOW);
    // cells ahead of the one just behind the centre
    localparam logic [WINDOW-1:0] LOW_MASK = WINDOW'((1 << (DELAY - 1)) - 1);

    logic                          adv;
    logic                          accept;
    logic                          shift;
    logic                          flush_end;
    logic                          room;
    logic                          push;
    out_word_t                     push_word;

    logic                          s0_valid_reg;
    logic                          s0_valid_next;
    logic                          s0_last_reg;
    logic signed [SAMPLE_BITS-1:0] s0_sample_reg;
    logic [SQ_BITS-1:0]            s0_sq_reg;
    logic signed [SQ_BITS-1:0]     sq_next;

    logic                          flushing_reg;
    logic                          flushing_next;
    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [SUM_W-1:0]       sum_next;
    logic [QSUM_W-1:0]             qsum_reg;
    logic [QSUM_W-1:0]             qsum_next;
    emit_t                         em_reg;
    emit_t                         em_next;

    cell_t                         entry;
    cell_t                         chain [WINDOW];
    logic [WINDOW-1:0]             cv;

    assign adv        = room;
    assign feed_stall = !room || flushing_reg || (s0_valid_reg && s0_last_reg);
    assign accept     = feed_valid && !feed_stall;
    assign shift      = adv && (s0_valid_reg || flushing_reg);
    // drain ends once no held sample remains ahead of the centre
    assign flush_end  = adv && flushing_reg && ((cv & LOW_MASK) == '0);

    assign sq_next = feed_data.sample * feed_data.sample;

    // empty filler enters the chain while draining
    always_comb
    begin
        entry.valid  = s0_valid_reg && !flushing_reg;
        entry.sample = flushing_reg ? '0 : s0_sample_reg;
        entry.sq     = flushing_reg ? '0 : s0_sq_reg;
    end

    always_comb
    begin
        s0_valid_next = adv ? accept : s0_valid_reg;

        priority if (flush_end)
        begin
            flushing_next = 1'b0;
        end
        else if (shift && !flushing_reg && s0_last_reg)
        begin
            flushing_next = 1'b1;
        end
        else
        begin
            flushing_next = flushing_reg;
        end

        // sums follow the cell contents, valid or not
        if (shift)
        begin
            sum_next  = sum_reg + SUM_W'(entry.sample) - SUM_W'(chain[WINDOW-1].sample);
            qsum_next = qsum_reg + QSUM_W'(entry.sq) - QSUM_W'(chain[WINDOW-1].sq);
        end
        else
        begin
            sum_next  = sum_reg;
            qsum_next = qsum_reg;
        end

        if (adv)
        begin
            em_next.valid = shift && cv[DELAY-1];
            em_next.test  = shift && !flushing_reg && cv[WINDOW-2];
            em_next.last  = flush_end;
        end
        else
        begin
            em_next = em_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            flushing_reg <= 1'b0;
            sum_reg      <= '0;
            qsum_reg     <= '0;
            em_reg       <= '0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            flushing_reg <= flushing_next;
            sum_reg      <= sum_next;
            qsum_reg     <= qsum_next;
            em_reg       <= em_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_last_reg   <= feed_data.last;
            s0_sample_reg <= feed_data.sample;
            s0_sq_reg     <= sq_next;
        end
    end

    // newest sample in cell 0, oldest in the last cell
    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            wsof_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .clear (flush_end),
                .prev  (entry),
                .cur   (chain[i])
            );
        end
        else
        begin : g_body
            wsof_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .clear (flush_end),
                .prev  (chain[i-1]),
                .cur   (chain[i])
            );
        end
        assign cv[i] = chain[i].valid;
    end

    wsof_decide #(
        .WINDOW (WINDOW)
    ) u_decide (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .em     (em_reg),
        .centre (chain[DELAY].sample),
        .sum    (sum_reg),
        .qsum   (qsum_reg),
        .push   (push),
        .word   (push_word)
    );

    wsof_skid u_skid (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .word  (push_word),
        .room  (room),
        .valid (result_valid),
        .stall (result_stall),
        .data  (result_data)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.last_out |-> result_data.keep)
        else $error("closing word of a stream marked as outlier");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(flushing_reg) |-> cv == '0)
        else $error("window still holds samples after drain");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(flushing_reg) |-> $past(s0_valid_reg && s0_last_reg))
        else $error("drain started without a last word");

    assert property (@(posedge clk) disable iff (!rst_n)
        em_reg.test |-> &cv)
        else $error("outlier test on a window that is not full");

endmodule

>>> hdl/wsof_cell.sv
// one window cell: sample, its square and an occupied flag, shifted from the neighbor
module wsof_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  logic            clear,
    input  wsof_pkg::cell_t prev,
    output wsof_pkg::cell_t cur
);
    import wsof_pkg::*;

    cell_t cell_reg;
    cell_t cell_next;

    always_comb
    begin
        cell_next = cell_reg;
        if (shift)
        begin
            cell_next = prev;
            if (clear)
            begin
                cell_next.valid = 1'b0;
            end
        end
    end

    // contents reset to zero so the running window sums start consistent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign cur = cell_reg;

endmodule

>>> hdl/wsof_decide.sv
// outlier decision pipeline: deviation and variance terms, squares, compare
module wsof_decide #(
    parameter int WINDOW = wsof_pkg::WINDOW_DEF,
    localparam int SUM_W  = wsof_pkg::SAMPLE_BITS + $clog2(WINDOW) + 1,
    localparam int QSUM_W = wsof_pkg::SQ_BITS + $clog2(WINDOW)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  wsof_pkg::emit_t                       em,
    input  logic signed [wsof_pkg::SAMPLE_BITS-1:0] centre,
    input  logic signed [SUM_W-1:0]               sum,
    input  logic [QSUM_W-1:0]                     qsum,
    output logic                                  push,
    output wsof_pkg::out_word_t                   word
);
    import wsof_pkg::*;

    localparam int D_W   = SUM_W + 2;
    localparam int VAR_W = 2 * SUM_W + 2;
    localparam int DD_W  = 2 * D_W;
    localparam logic signed [D_W-1:0] W_D = D_W'(WINDOW);
    localparam logic [VAR_W-1:0]      W_V = VAR_W'(WINDOW);

    emit_t                         p2_ctrl_reg;
    emit_t                         p3_ctrl_reg;
    logic signed [SAMPLE_BITS-1:0] p2_sample_reg;
    logic signed [SAMPLE_BITS-1:0] p3_sample_reg;
    logic signed [D_W-1:0]         p2_dev_reg;
    logic [VAR_W-1:0]              p2_wq_reg;
    logic signed [2*SUM_W-1:0]     p2_ss_reg;
    logic signed [DD_W-1:0]        p3_dd_reg;
    logic signed [VAR_W-1:0]       p3_var_reg;

    logic signed [D_W-1:0]         dev_next;
    logic [VAR_W-1:0]              wq_next;
    logic signed [2*SUM_W-1:0]     ss_next;
    logic signed [DD_W-1:0]        dd_next;
    logic signed [VAR_W-1:0]       var_next;

    // W*v - S, W*Q and S^2
    assign dev_next = W_D * D_W'(centre) - D_W'(sum);
    assign wq_next  = W_V * VAR_W'(qsum);
    assign ss_next  = sum * sum;

    // (W*v - S)^2 and W*Q - S^2
    assign dd_next  = p2_dev_reg * p2_dev_reg;
    assign var_next = $signed(p2_wq_reg) - VAR_W'(p2_ss_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_ctrl_reg <= '0;
            p3_ctrl_reg <= '0;
        end
        else if (adv)
        begin
            p2_ctrl_reg <= em;
            p3_ctrl_reg <= p2_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_sample_reg <= centre;
            p2_dev_reg    <= dev_next;
            p2_wq_reg     <= wq_next;
            p2_ss_reg     <= ss_next;
            p3_sample_reg <= p2_sample_reg;
            p3_dd_reg     <= dd_next;
            p3_var_reg    <= var_next;
        end
    end

    assign push            = adv && p3_ctrl_reg.valid;
    assign word.sample_out = p3_sample_reg;
    assign word.keep       = !(p3_ctrl_reg.test && (p3_dd_reg > DD_W'(p3_var_reg)));
    assign word.last_out   = p3_ctrl_reg.last;

endmodule

>>> hdl/wsof_skid.sv
// two-word output buffer that decouples the pipeline from the result stall
module wsof_skid (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wsof_pkg::out_word_t word,
    output logic                room,
    output logic                valid,
    input  logic                stall,
    output wsof_pkg::out_word_t data
);
    import wsof_pkg::*;

    localparam logic [1:0] DEPTH = 2'd2;

    out_word_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop   = valid && !stall;
    assign valid = count_reg != 2'd0;
    assign room  = count_reg != DEPTH;
    assign data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= word;
        end
    end

endmodule

>>> verif/tb_window_sigma_outlier_filter_top.sv
// testbench for the window sigma outlier filter: streams of samples against a scoreboard
`timescale 1ns / 1ps

module tb_window_sigma_outlier_filter_top;

    import wsof_pkg::*;

    localparam int WINDOW   = WINDOW_DEF;
    localparam int CENTRE   = (WINDOW - 1) / 2;
    localparam int DELAY    = WINDOW - 1 - CENTRE;
    localparam int ITEMS    = 380;
    localparam int LIMIT    = 200000;
    localparam int MAX_NOTE = 20;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef enum int {SHAPE_NOISY, SHAPE_RAW, SHAPE_FLAT, SHAPE_EDGE} shape_t;

    class filter_scoreboard;
        sample_t   win[WINDOW];
        int        fill;
        out_word_t due_words[$];
        int        mismatches;

        function new();
            clear_window();
            mismatches = 0;
        endfunction

        function void clear_window();
            foreach (win[i]) win[i] = '0;
            fill = 0;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        function void push_word(sample_t v, logic keep, logic last_out);
            out_word_t o;
            o.sample_out = v;
            o.keep       = keep;
            o.last_out   = last_out;
            due_words.push_back(o);
        endfunction

        // exact integer form of |v - mean| > sigma over the full window
        function logic is_outlier();
            longint sum_s;
            longint sum_q;
            longint dev;
            longint spread;
            sum_s = 0;
            sum_q = 0;
            for (int i = 0; i < WINDOW; i++)
            begin
                sum_s += longint'(win[i]);
                sum_q += longint'(win[i]) * longint'(win[i]);
            end
            dev    = WINDOW * longint'(win[DELAY]) - sum_s;
            spread = WINDOW * sum_q - sum_s * sum_s;
            return dev * dev > spread;
        endfunction

        function void take_sample(in_word_t w);
            int held;
            logic drop;
            for (int i = WINDOW - 1; i > 0; i--)
                win[i] = win[i-1];
            win[0] = w.sample;
            if (fill < WINDOW)
                fill++;
            if (fill > DELAY)
            begin
                drop = (fill == WINDOW) ? is_outlier() : 1'b0;
                push_word(win[DELAY], !drop, 1'b0);
            end
            if (w.last)
            begin
                // flush what is still held, oldest first
                held = (fill > DELAY) ? DELAY : fill;
                for (int i = held - 1; i >= 0; i--)
                    push_word(win[i], 1'b1, i == 0);
                clear_window();
            end
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            if (due_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_NOTE)
                    $display("%0t unexpected word: actual sample %0d keep %0b last %0b",
                             $time, got.sample_out, got.keep, got.last_out);
                return;
            end
            want = due_words.pop_front();
            if (got.sample_out !== want.sample_out || got.keep !== want.keep ||
                got.last_out !== want.last_out)
            begin
                mismatches++;
                if (mismatches <= MAX_NOTE)
                    $display({"%0t mismatch: expected sample %0d keep %0b last %0b, ",
                              "actual sample %0d keep %0b last %0b"},
                             $time, want.sample_out, want.keep, want.last_out,
                             got.sample_out, got.keep, got.last_out);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      feed_valid;
    logic      feed_stall;
    in_word_t  feed_data;
    logic      result_valid;
    logic      result_stall;
    out_word_t result_data;

    filter_scoreboard sb;
    bit  calm;
    bit  quiet;
    int  cycles;
    int  sent;

    window_sigma_outlier_filter_top #(.WINDOW(WINDOW)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .feed_valid   (feed_valid),
        .feed_stall   (feed_stall),
        .feed_data    (feed_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // result side: random stall bursts, none started while calm or near the end
    initial
    begin
        int stall_left;
        stall_left   = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (!calm && !quiet && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_word(result_data);
    end

    task automatic send_word(in_word_t w);
        @(negedge clk);
        if (!calm && !quiet && $urandom_range(0, 3) == 0)
        begin
            feed_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        feed_valid <= 1'b1;
        feed_data  <= w;
        do
            @(posedge clk);
        while (feed_stall);
        sb.take_sample(w);
        sent++;
    endtask

    task automatic send_stream(sample_t vals[$]);
        in_word_t w;
        foreach (vals[i])
        begin
            w.sample = vals[i];
            w.last   = (i == vals.size() - 1);
            send_word(w);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        feed_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    function automatic sample_t clamp(int r);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[SAMPLE_BITS-1:0];
    endfunction

    function automatic sample_t pick_value(shape_t shape, int base);
        int r;
        case (shape)
            SHAPE_NOISY:
            begin
                r = base + int'($urandom_range(0, 100)) - 50;
                // occasional spike well outside the spread
                if ($urandom_range(0, 6) == 0)
                    r = base + ($urandom_range(0, 1) ? 1 : -1) *
                               int'($urandom_range(2000, 20000));
                return clamp(r);
            end
            SHAPE_RAW:
                return sample_t'($urandom);
            SHAPE_FLAT:
                return ($urandom_range(0, 12) == 0) ? clamp(base + int'($urandom_range(1, 9)))
                                                    : clamp(base);
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'sh7fff;
                    1: return 16'sh8000;
                    2: return '0;
                    3: return '1;
                    default: return 16'sd1;
                endcase
            end
        endcase
    endfunction

    initial
    begin
        sample_t vals[$];
        shape_t  shape;
        int      len;
        int      base;
        int      streams;

        sb           = new();
        rst_n        = 1'b0;
        feed_valid   = 1'b0;
        feed_data    = '0;
        calm         = 1'b0;
        quiet        = 1'b0;
        sent         = 0;
        streams      = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // short streams: last before the window fills
        send_stream('{16'sh7fff});
        send_stream('{16'sh8000, 16'sh7fff});
        send_stream('{16'sd100, -16'sd100, 16'sd5});
        // flat stream, zero spread never marks a drop
        send_stream('{16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7});
        // spikes and extremes inside full windows
        send_stream('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd30000, 16'sd0, 16'sd0,
                      16'sh8000, 16'sh7fff, 16'sd0});
        send_stream('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
        drain_results();

        while (sent < ITEMS)
        begin
            streams++;
            calm  = ($urandom_range(0, 3) == 0);
            quiet = (sent > ITEMS - 60);
            shape = shape_t'($urandom_range(0, 9) < 5 ? SHAPE_NOISY : $urandom_range(1, 3));
            base  = int'($urandom_range(0, 40000)) - 20000;
            len   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
            vals.delete();
            repeat (len) vals.push_back(pick_value(shape, base));
            send_stream(vals);
            if (streams == 6)
                drain_results();
        end

        drain_results();
        repeat (8) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
